>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the surface normal RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define DSN_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked property, checked in every cycle
`define DSN_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> hw/rtl/dsn_pkg.sv
// Types and constants for the depth surface normal unit
package dsn_pkg;

  localparam int COORD_BITS       = 11;
  localparam int DEPTH_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int DIM_BITS      = 12;
  localparam int FOCAL_BITS    = 32;
  localparam int LIMIT_BITS    = 16;

  localparam int CMP_BITS  = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
  localparam int DLIM_BITS = (DEPTH_BITS > LIMIT_BITS) ? DEPTH_BITS : LIMIT_BITS;
  localparam int DIFF_BITS = DEPTH_BITS + 2;
  localparam int MAG_BITS  = DEPTH_BITS + 1;

  localparam int VSHIFT      = 19;
  localparam int PROD_X_BITS = MAG_BITS + FOCAL_BITS;
  localparam int PROD_Z_BITS = 2 * FOCAL_BITS;
  localparam int VEC_RAW     = PROD_X_BITS + VSHIFT;
  localparam int VEC_BITS    = (VEC_RAW > PROD_Z_BITS) ? VEC_RAW : PROD_Z_BITS;

  localparam int NORM_BITS = 31;
  localparam int SQR_BITS  = 2 * NORM_BITS;
  localparam int SUM_BITS  = 64;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 4;

  localparam int XY_BITS   = NORMAL_FRAC_BITS + 2;
  localparam int Z_BITS    = NORMAL_FRAC_BITS + 1;
  localparam int QB_BITS   = ((NORMAL_FRAC_BITS + 2) / 2) * 2;
  localparam int NUM_BITS  = NORM_BITS + NORMAL_FRAC_BITS + 1;
  localparam int DREM_BITS = ROOT_BITS + 1;

  localparam logic [Z_BITS-1:0] Z_ONE = Z_BITS'(1) << NORMAL_FRAC_BITS;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_HALF_MODE    = 3'd0,
    CFG_IMAGE_WIDTH  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_INV_FOCAL_X  = 3'd3,
    CFG_INV_FOCAL_Y  = 3'd4,
    CFG_DELTA_LIMIT  = 3'd5
  } cfg_reg_t;

  localparam logic                  RST_HALF_MODE    = 1'b0;
  localparam logic [DIM_BITS-1:0]   RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [DIM_BITS-1:0]   RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [FOCAL_BITS-1:0] RST_INV_FOCAL_X  = 32'd6710886;
  localparam logic [FOCAL_BITS-1:0] RST_INV_FOCAL_Y  = 32'd8947849;
  localparam logic [LIMIT_BITS-1:0] RST_DELTA_LIMIT  = 16'd65535;

  typedef struct packed {
    logic                  half_mode;
    logic [DIM_BITS-1:0]   image_width;
    logic [DIM_BITS-1:0]   image_height;
    logic [FOCAL_BITS-1:0] inv_focal_x;
    logic [FOCAL_BITS-1:0] inv_focal_y;
    logic [LIMIT_BITS-1:0] jump_limit;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic [DEPTH_BITS-1:0] depth_center;
    logic [DEPTH_BITS-1:0] depth_left;
    logic [DEPTH_BITS-1:0] depth_right;
    logic [DEPTH_BITS-1:0] depth_north;
    logic [DEPTH_BITS-1:0] depth_south;
  } pixel_word_t;

  typedef struct packed {
    logic                      normal_valid;
    logic signed [XY_BITS-1:0] normal_x;
    logic signed [XY_BITS-1:0] normal_y;
    logic [Z_BITS-1:0]         normal_z;
  } normal_word_t;

  typedef struct packed {
    logic                 ok;
    logic                 neg_x;
    logic                 neg_y;
    logic [NORM_BITS-1:0] a;
    logic [NORM_BITS-1:0] b;
    logic [NORM_BITS-1:0] c;
  } vec_word_t;

  typedef struct packed {
    logic                 ok;
    logic                 neg_x;
    logic                 neg_y;
    logic [NORM_BITS-1:0] a;
    logic [NORM_BITS-1:0] b;
    logic [NORM_BITS-1:0] c;
    logic [ROOT_BITS-1:0] root;
  } root_word_t;

endpackage

>>> hw/rtl/dsn_front.sv
// Pixel checks, difference products and block normalisation of the vector
module dsn_front
  import dsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        vld_i,
  output logic        stall_o,
  input  pixel_word_t data_i,
  output logic        vld_o,
  input  logic        stall_i,
  output vec_word_t   data_o
);

  localparam int NST      = 5;
  localparam int CHUNK    = 8;
  localparam int CL_BITS  = $clog2(CHUNK);
  localparam int NCH      = (VEC_BITS + CHUNK - 1) / CHUNK;
  localparam int PAD_BITS = NCH * CHUNK;
  localparam int LZ_BITS  = $clog2(PAD_BITS);

  function automatic logic [DLIM_BITS-1:0] depth_absdiff(logic [DEPTH_BITS-1:0] p,
                                                         logic [DEPTH_BITS-1:0] q);
    logic [DEPTH_BITS-1:0] d;
    d = (p > q) ? p - q : q - p;
    return DLIM_BITS'(d);
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || !stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign vld_o   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? vld_i : vld[k-1];
        end
      end
    end
  end

  // stage 1: window, missing depth and jump checks; differences
  logic [CMP_BITS-1:0]         row_e, col_e, wid_e, hgt_e;
  logic [DLIM_BITS-1:0]        lim;
  logic                        inside_ok, zero_ok, jump_ok;
  logic signed [DIFF_BITS-1:0] sc, sl, sr, sn, ss, dx, dy, mx, my;

  always_comb begin
    row_e = CMP_BITS'(data_i.pixel_row);
    col_e = CMP_BITS'(data_i.pixel_col);
    wid_e = CMP_BITS'(cfg.image_width);
    hgt_e = CMP_BITS'(cfg.image_height);
    lim   = DLIM_BITS'(cfg.jump_limit);
    if (cfg.half_mode) begin
      inside_ok = row_e >= CMP_BITS'(1) && col_e >= CMP_BITS'(1)
                  && row_e < hgt_e && col_e < wid_e;
    end else begin
      inside_ok = row_e >= CMP_BITS'(1) && col_e >= CMP_BITS'(1)
                  && row_e + CMP_BITS'(1) < hgt_e && col_e + CMP_BITS'(1) < wid_e;
    end
    zero_ok = data_i.depth_center != '0 && data_i.depth_left != '0
              && data_i.depth_north != '0
              && (cfg.half_mode || (data_i.depth_right != '0 && data_i.depth_south != '0));
    jump_ok = depth_absdiff(data_i.depth_left, data_i.depth_center) <= lim
              && depth_absdiff(data_i.depth_north, data_i.depth_center) <= lim
              && (cfg.half_mode
                  || (depth_absdiff(data_i.depth_right, data_i.depth_center) <= lim
                      && depth_absdiff(data_i.depth_south, data_i.depth_center) <= lim));
    sc = $signed({2'b00, data_i.depth_center});
    sl = $signed({2'b00, data_i.depth_left});
    sr = $signed({2'b00, data_i.depth_right});
    sn = $signed({2'b00, data_i.depth_north});
    ss = $signed({2'b00, data_i.depth_south});
    if (cfg.half_mode) begin
      dx = (sl - sc) <<< 1;
      dy = (sc - sn) <<< 1;
    end else begin
      dx = sl - sr;
      dy = ss - sn;
    end
    mx = dx[DIFF_BITS-1] ? -dx : dx;
    my = dy[DIFF_BITS-1] ? -dy : dy;
  end

  logic                ok1, negx1, negy1;
  logic [MAG_BITS-1:0] magx1, magy1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok1   <= inside_ok && zero_ok && jump_ok;
      negx1 <= !dx[DIFF_BITS-1] && dx != '0;
      negy1 <= !dy[DIFF_BITS-1] && dy != '0;
      magx1 <= mx[MAG_BITS-1:0];
      magy1 <= my[MAG_BITS-1:0];
    end
  end

  // stage 2: products
  logic                   ok2, negx2, negy2;
  logic [PROD_X_BITS-1:0] prx2, pry2;
  logic [PROD_Z_BITS-1:0] prz2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ok2   <= ok1;
      negx2 <= negx1;
      negy2 <= negy1;
      prx2  <= PROD_X_BITS'(magx1) * PROD_X_BITS'(cfg.inv_focal_y);
      pry2  <= PROD_X_BITS'(magy1) * PROD_X_BITS'(cfg.inv_focal_x);
      prz2  <= PROD_Z_BITS'(cfg.inv_focal_x) * PROD_Z_BITS'(cfg.inv_focal_y);
    end
  end

  // stage 3: leading zeros per chunk of the combined magnitude
  logic [VEC_BITS-1:0] orw;
  logic [PAD_BITS-1:0] padw;
  logic [CHUNK-1:0]    chk;
  logic [NCH-1:0]      nz_c;
  logic [CL_BITS-1:0]  cl_c [NCH];

  always_comb begin
    orw  = VEC_BITS'({prx2, {VSHIFT{1'b0}}}) | VEC_BITS'({pry2, {VSHIFT{1'b0}}})
           | VEC_BITS'(prz2);
    padw = PAD_BITS'(orw) << (PAD_BITS - VEC_BITS);
    chk  = '0;
    for (int j = 0; j < NCH; j++) begin
      chk     = padw[PAD_BITS-1-j*CHUNK -: CHUNK];
      nz_c[j] = |chk;
      cl_c[j] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        if (chk[b]) begin
          cl_c[j] = CL_BITS'(CHUNK - 1 - b);
        end
      end
    end
  end

  logic                   ok3, negx3, negy3;
  logic [PROD_X_BITS-1:0] prx3, pry3;
  logic [PROD_Z_BITS-1:0] prz3;
  logic [NCH-1:0]         nz3;
  logic [CL_BITS-1:0]     cl3 [NCH];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ok3   <= ok2;
      negx3 <= negx2;
      negy3 <= negy2;
      prx3  <= prx2;
      pry3  <= pry2;
      prz3  <= prz2;
      nz3   <= nz_c;
      cl3   <= cl_c;
    end
  end

  // stage 4: total leading zero count
  logic [LZ_BITS-1:0] lz_c;

  always_comb begin
    lz_c = '0;
    for (int j = NCH - 1; j >= 0; j--) begin
      if (nz3[j]) begin
        lz_c = LZ_BITS'(j * CHUNK) + LZ_BITS'(cl3[j]);
      end
    end
  end

  logic                   ok4, negx4, negy4;
  logic [PROD_X_BITS-1:0] prx4, pry4;
  logic [PROD_Z_BITS-1:0] prz4;
  logic [LZ_BITS-1:0]     lz4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ok4   <= ok3 && (|nz3);
      negx4 <= negx3;
      negy4 <= negy3;
      prx4  <= prx3;
      pry4  <= pry3;
      prz4  <= prz3;
      lz4   <= lz_c;
    end
  end

  // stage 5: shift so the largest magnitude fills the top bit
  logic [VEC_BITS-1:0] sa, sb, sc5;

  always_comb begin
    sa  = VEC_BITS'({prx4, {VSHIFT{1'b0}}}) << lz4;
    sb  = VEC_BITS'({pry4, {VSHIFT{1'b0}}}) << lz4;
    sc5 = VEC_BITS'(prz4) << lz4;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      data_o.ok    <= ok4;
      data_o.neg_x <= negx4;
      data_o.neg_y <= negy4;
      data_o.a     <= sa[VEC_BITS-1 -: NORM_BITS];
      data_o.b     <= sb[VEC_BITS-1 -: NORM_BITS];
      data_o.c     <= sc5[VEC_BITS-1 -: NORM_BITS];
    end
  end

endmodule

>>> hw/rtl/dsn_sqrt.sv
// Sum of squares and pipelined integer square root
`include "assert_macros.svh"
module dsn_sqrt
  import dsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       vld_i,
  output logic       stall_o,
  input  vec_word_t  data_i,
  output logic       vld_o,
  input  logic       stall_i,
  output root_word_t data_o
);

  localparam int STEPS     = 2;
  localparam int SQ_STAGES = ROOT_BITS / STEPS;
  localparam int NST       = SQ_STAGES + 2;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || !stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign vld_o   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? vld_i : vld[k-1];
        end
      end
    end
  end

  // squares
  vec_word_t           w0;
  logic [SQR_BITS-1:0] sqa, sqb, sqc;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w0  <= data_i;
      sqa <= SQR_BITS'(data_i.a) * SQR_BITS'(data_i.a);
      sqb <= SQR_BITS'(data_i.b) * SQR_BITS'(data_i.b);
      sqc <= SQR_BITS'(data_i.c) * SQR_BITS'(data_i.c);
    end
  end

  // sum
  vec_word_t           w1;
  logic [SUM_BITS-1:0] s1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w1 <= w0;
      s1 <= SUM_BITS'(sqa) + SUM_BITS'(sqb) + SUM_BITS'(sqc);
    end
  end

  // root digits, two per stage
  logic [REM_BITS-1:0]  rem_q  [SQ_STAGES];
  logic [ROOT_BITS-1:0] root_q [SQ_STAGES];
  logic [SUM_BITS-1:0]  sr_q   [SQ_STAGES];
  vec_word_t            w_q    [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_it
    logic [REM_BITS-1:0]  rem_in, rem_c;
    logic [ROOT_BITS-1:0] root_in, root_c;
    logic [SUM_BITS-1:0]  sr_in, sr_c;
    logic [ROOT_BITS+1:0] trial;
    vec_word_t            w_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sr_in   = s1;
      assign w_in    = w1;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign sr_in   = sr_q[g-1];
      assign w_in    = w_q[g-1];
    end

    always_comb begin
      rem_c  = rem_in;
      root_c = root_in;
      sr_c   = sr_in;
      trial  = '0;
      for (int i = 0; i < STEPS; i++) begin
        rem_c = {rem_c[REM_BITS-3:0], sr_c[SUM_BITS-1 -: 2]};
        sr_c  = {sr_c[SUM_BITS-3:0], 2'b00};
        trial = {root_c, 2'b01};
        if (rem_c >= REM_BITS'(trial)) begin
          rem_c  = rem_c - REM_BITS'(trial);
          root_c = {root_c[ROOT_BITS-2:0], 1'b1};
        end else begin
          root_c = {root_c[ROOT_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g+2]) begin
        rem_q[g]  <= rem_c;
        root_q[g] <= root_c;
        sr_q[g]   <= sr_c;
        w_q[g]    <= w_in;
      end
    end
  end

  always_comb begin
    data_o.ok    = w_q[SQ_STAGES-1].ok;
    data_o.neg_x = w_q[SQ_STAGES-1].neg_x;
    data_o.neg_y = w_q[SQ_STAGES-1].neg_y;
    data_o.a     = w_q[SQ_STAGES-1].a;
    data_o.b     = w_q[SQ_STAGES-1].b;
    data_o.c     = w_q[SQ_STAGES-1].c;
    data_o.root  = root_q[SQ_STAGES-1];
  end

  logic root_covers;

  assign root_covers = data_o.root >= ROOT_BITS'(data_o.a)
                       && data_o.root >= ROOT_BITS'(data_o.b)
                       && data_o.root >= ROOT_BITS'(data_o.c);

  // the root never falls below any single component
  `DSN_ASSERT(a_root_covers, clk, rst, vld_o && data_o.ok |-> root_covers, "root below a component")

endmodule

>>> hw/rtl/dsn_div.sv
// Pipelined rounded division of the components by the root, and output register
`include "assert_macros.svh"
module dsn_div
  import dsn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         vld_i,
  output logic         stall_o,
  input  root_word_t   data_i,
  output logic         vld_o,
  input  logic         stall_i,
  output normal_word_t data_o
);

  localparam int STEPS      = 2;
  localparam int DIV_STAGES = QB_BITS / STEPS;
  localparam int NST        = DIV_STAGES + 2;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || !stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign vld_o   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? vld_i : vld[k-1];
        end
      end
    end
  end

  // numerators with half the root added for rounding
  logic [NORM_BITS-1:0] comp [3];
  logic [NUM_BITS-1:0]  num  [3];

  always_comb begin
    comp[0] = data_i.a;
    comp[1] = data_i.b;
    comp[2] = data_i.c;
    for (int k = 0; k < 3; k++) begin
      num[k] = (NUM_BITS'(comp[k]) << NORMAL_FRAC_BITS)
               + NUM_BITS'(data_i.root[ROOT_BITS-1:1]);
    end
  end

  logic                            ok0, negx0, negy0;
  logic [ROOT_BITS-1:0]            root0;
  logic [2:0][DREM_BITS-1:0]       drem0;
  logic [2:0][QB_BITS-1:0]         lo0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ok0   <= data_i.ok;
      negx0 <= data_i.neg_x;
      negy0 <= data_i.neg_y;
      root0 <= data_i.root;
      for (int k = 0; k < 3; k++) begin
        drem0[k] <= DREM_BITS'(num[k] >> QB_BITS);
        lo0[k]   <= num[k][QB_BITS-1:0];
      end
    end
  end

  // quotient bits, two per stage; numerator bits shift out as quotient bits shift in
  logic                      ok_q   [DIV_STAGES];
  logic                      negx_q [DIV_STAGES];
  logic                      negy_q [DIV_STAGES];
  logic [ROOT_BITS-1:0]      root_q [DIV_STAGES];
  logic [2:0][DREM_BITS-1:0] drem_q [DIV_STAGES];
  logic [2:0][QB_BITS-1:0]   lo_q   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_it
    logic                      ok_in, negx_in, negy_in;
    logic [ROOT_BITS-1:0]      root_in;
    logic [2:0][DREM_BITS-1:0] drem_in, drem_c;
    logic [2:0][QB_BITS-1:0]   lo_in, lo_c;
    logic                      qbit;

    if (g == 0) begin : g_first
      assign ok_in   = ok0;
      assign negx_in = negx0;
      assign negy_in = negy0;
      assign root_in = root0;
      assign drem_in = drem0;
      assign lo_in   = lo0;
    end else begin : g_next
      assign ok_in   = ok_q[g-1];
      assign negx_in = negx_q[g-1];
      assign negy_in = negy_q[g-1];
      assign root_in = root_q[g-1];
      assign drem_in = drem_q[g-1];
      assign lo_in   = lo_q[g-1];
    end

    always_comb begin
      drem_c = drem_in;
      lo_c   = lo_in;
      qbit   = 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < STEPS; i++) begin
          drem_c[k] = {drem_c[k][DREM_BITS-2:0], lo_c[k][QB_BITS-1]};
          qbit      = drem_c[k] >= DREM_BITS'(root_in);
          if (qbit) begin
            drem_c[k] = drem_c[k] - DREM_BITS'(root_in);
          end
          lo_c[k] = {lo_c[k][QB_BITS-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g+1]) begin
        ok_q[g]   <= ok_in;
        negx_q[g] <= negx_in;
        negy_q[g] <= negy_in;
        root_q[g] <= root_in;
        drem_q[g] <= drem_c;
        lo_q[g]   <= lo_c;
      end
    end
  end

  // signs and rejection
  normal_word_t              word_c;
  logic signed [XY_BITS-1:0] nx, ny;

  always_comb begin
    nx = XY_BITS'(lo_q[DIV_STAGES-1][0]);
    ny = XY_BITS'(lo_q[DIV_STAGES-1][1]);
    word_c = '0;
    if (ok_q[DIV_STAGES-1]) begin
      word_c.normal_valid = 1'b1;
      word_c.normal_x     = negx_q[DIV_STAGES-1] ? -nx : nx;
      word_c.normal_y     = negy_q[DIV_STAGES-1] ? -ny : ny;
      word_c.normal_z     = Z_BITS'(lo_q[DIV_STAGES-1][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      data_o <= word_c;
    end
  end

  `DSN_ASSERT(a_root_nonzero, clk, rst, vld_i && data_i.ok |-> data_i.root != '0, "zero root")

endmodule

>>> hw/rtl/depth_surface_normal_unit.sv
// Top level of the depth surface normal unit: registers and pipeline
//
//   channel   valid        stall        word
//   ------------------------------------------------------
//   pixel in  pixel_valid  pixel_stall  pixel_word
//   normal    nrm_valid    nrm_stall    nrm_word
//   config    cfg_wr_en    -            cfg_addr, cfg_wdata
//
// One pixel per cycle unless a stall holds the pipeline; the stages a pixel passes are:
// 5 front stages, 18 for squares, sum and root (two root bits a stage),
// 10 for the divisions (two quotient bits a stage) and the output register.
// Synchronous reset empties the pipeline and loads the register defaults.
// A stall holds only the stages that are full; bubbles still close up.
`include "assert_macros.svh"
module depth_surface_normal_unit
  import dsn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     pixel_valid,
  output logic                     pixel_stall,
  input  pixel_word_t              pixel_word,
  output logic                     nrm_valid,
  input  logic                     nrm_stall,
  output normal_word_t             nrm_word
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_mode    <= RST_HALF_MODE;
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.inv_focal_x  <= RST_INV_FOCAL_X;
      cfg.inv_focal_y  <= RST_INV_FOCAL_Y;
      cfg.jump_limit   <= RST_DELTA_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_HALF_MODE:    cfg.half_mode    <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_wdata[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_wdata[DIM_BITS-1:0];
        CFG_INV_FOCAL_X:  cfg.inv_focal_x  <= cfg_wdata[FOCAL_BITS-1:0];
        CFG_INV_FOCAL_Y:  cfg.inv_focal_y  <= cfg_wdata[FOCAL_BITS-1:0];
        CFG_DELTA_LIMIT:  cfg.jump_limit   <= cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic       vec_vld, vec_stall;
  vec_word_t  vec_word;
  logic       root_vld, root_stall;
  root_word_t root_word;

  dsn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .vld_i   (pixel_valid),
    .stall_o (pixel_stall),
    .data_i  (pixel_word),
    .vld_o   (vec_vld),
    .stall_i (vec_stall),
    .data_o  (vec_word)
  );

  dsn_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_i   (vec_vld),
    .stall_o (vec_stall),
    .data_i  (vec_word),
    .vld_o   (root_vld),
    .stall_i (root_stall),
    .data_o  (root_word)
  );

  dsn_div u_div (
    .clk     (clk),
    .rst     (rst),
    .vld_i   (root_vld),
    .stall_o (root_stall),
    .data_i  (root_word),
    .vld_o   (nrm_valid),
    .stall_i (nrm_stall),
    .data_o  (nrm_word)
  );

  logic nrm_zero;
  logic nrm_reject;

  assign nrm_zero   = nrm_word.normal_x == '0 && nrm_word.normal_y == '0
                      && nrm_word.normal_z == '0;
  assign nrm_reject = nrm_valid && !nrm_word.normal_valid;

  `DSN_ASSERT(a_reject_zero, clk, rst, nrm_reject |-> nrm_zero, "rejected pixel with nonzero normal")
  `DSN_ASSERT(a_z_unit, clk, rst, nrm_valid |-> nrm_word.normal_z <= Z_ONE, "normal z above one")
  `DSN_ASSERT(a_flow_through, clk, rst, !nrm_stall |-> !pixel_stall, "input stalled while output free")

endmodule
